// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define IFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when cond holds, then holds in the next cycle.
`define IFD_ASSERT_NEXT(label, cond, then_expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (then_expr)) else $error(msg);

`endif

// File: hdl/ifd_pkg.sv
// Shared types and constants of the frame deframer.
// No dependencies.
package ifd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CAPT_BYTES = 24;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFA;
  localparam logic [BYTE_W-1:0] LENGTH_BYTE   = 8'h1A;
  localparam logic [BYTE_W-1:0] BUS_ADDR_RST  = 8'hFF;
  localparam logic [BYTE_W-1:0] MSG_ID_RST    = 8'h32;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID  = 8'd1;

  localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
  localparam logic [POS_W-1:0] POS_ADDR      = 5'd1;
  localparam logic [POS_W-1:0] POS_ID        = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN       = 5'd3;
  localparam logic [POS_W-1:0] POS_PAYLOAD   = 5'd4;
  localparam logic [POS_W-1:0] POS_LAST_CAPT = 5'd27;
  localparam logic [POS_W-1:0] POS_LAST_PAY  = 5'd29;
  localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd30;

  localparam logic [WORD_W-2:0] F_ONE  = 31'h3F800000;
  localparam logic [WORD_W-2:0] F_90   = 31'h42B40000;
  localparam logic [WORD_W-2:0] F_180  = 31'h43340000;
  localparam logic [WORD_W-2:0] F_200  = 31'h43480000;
  localparam logic [WORD_W-2:0] F_1000 = 31'h447A0000;

  typedef struct packed {
    logic [WORD_W-1:0] roll;
    logic [WORD_W-1:0] pitch;
    logic [WORD_W-1:0] yaw;
    logic [WORD_W-1:0] lat;
    logic [WORD_W-1:0] lon;
    logic [WORD_W-1:0] alt;
  } frame_t;

endpackage

// File: hdl/ifd_front.sv
// Front end: header hunt, running checksum and payload capture.
// Depends on ifd_pkg.
module ifd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ifd_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          acc_i,
  input  logic [ifd_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          push_o,
  output ifd_pkg::frame_t               frame_o
);
  import ifd_pkg::*;

  logic [BYTE_W-1:0]            bus_addr_q, msg_id_q;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [BYTE_W-1:0]            sum_q, sum_d, sum_add, want;
  logic [CAPT_BYTES*BYTE_W-1:0] data_q;
  logic                         shift_en;

  assign sum_add = BYTE_W'(sum_q + rx_byte_i);
  assign want = (pos_q == POS_ADDR) ? bus_addr_q :
                (pos_q == POS_ID)   ? msg_id_q : LENGTH_BYTE;

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    shift_en = 1'b0;
    push_o   = 1'b0;
    if (acc_i) begin
      if (pos_q inside {POS_ADDR, POS_ID, POS_LEN}) begin
        if (rx_byte_i == want) begin
          sum_d = sum_add;
          pos_d = POS_W'(pos_q + 5'd1);
        end else begin
          sum_d = '0;
          pos_d = (rx_byte_i == PREAMBLE_BYTE) ? POS_ADDR : POS_HUNT;
        end
      end else if (pos_q inside {[POS_PAYLOAD:POS_LAST_PAY]}) begin
        shift_en = (pos_q <= POS_LAST_CAPT);
        sum_d    = sum_add;
        pos_d    = POS_W'(pos_q + 5'd1);
      end else if (pos_q == POS_CHECKSUM) begin
        sum_d  = '0;
        pos_d  = POS_HUNT;
        push_o = (sum_add == '0);
      end else begin
        sum_d = '0;
        pos_d = (rx_byte_i == PREAMBLE_BYTE) ? POS_ADDR : POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_HUNT;
      sum_q      <= '0;
      bus_addr_q <= BUS_ADDR_RST;
      msg_id_q   <= MSG_ID_RST;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (cfg_we_i && cfg_index_i == CFG_BUS_ADDRESS) begin
        bus_addr_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_MESSAGE_ID) begin
        msg_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      data_q <= {data_q[(CAPT_BYTES-1)*BYTE_W-1:0], rx_byte_i};
    end
  end

  assign frame_o = frame_t'(data_q);

endmodule

// File: hdl/ifd_fifo.sv
// Two-entry frame queue between front and back end.
// Depends on ifd_pkg.
module ifd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifd_pkg::frame_t wdata_i,
  input  logic            pop_i,
  output ifd_pkg::frame_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import ifd_pkg::*;

  frame_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= QPTR_W'(wr_q + 1'b1);
      end
      if (pop_i) begin
        rd_q <= QPTR_W'(rd_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= QCNT_W'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= QCNT_W'(cnt_q - 1'b1);
      end
    end
  end

endmodule

// File: hdl/ifd_back.sv
// Back end: plausibility check and output register.
// Depends on ifd_pkg.
module ifd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  ifd_pkg::frame_t            frame_i,
  output logic                       pop_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output ifd_pkg::frame_t            frame_o,
  output logic                       in_range_o
);
  import ifd_pkg::*;

  logic   out_valid_q, in_range_q, bad;
  frame_t frame_q;

  function automatic logic outside(logic [WORD_W-1:0] bits, logic [WORD_W-2:0] lo,
                                   logic [WORD_W-2:0] hi);
    logic [WORD_W-2:0] mag;
    mag = bits[WORD_W-2:0];
    return bits[WORD_W-1] ? (mag > lo) : (mag > hi);
  endfunction

  function automatic logic near_zero(logic [WORD_W-1:0] bits);
    return bits[WORD_W-2:0] < F_ONE;
  endfunction

  assign bad = outside(frame_i.roll, F_180, F_180) ||
               outside(frame_i.pitch, F_180, F_180) ||
               outside(frame_i.yaw, F_180, F_180) || near_zero(frame_i.yaw) ||
               outside(frame_i.lat, F_90, F_90) || near_zero(frame_i.lat) ||
               outside(frame_i.lon, F_180, F_180) || near_zero(frame_i.lon) ||
               outside(frame_i.alt, F_200, F_1000) || near_zero(frame_i.alt);

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q    <= frame_i;
      in_range_q <= !bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;
  assign in_range_o  = in_range_q;

endmodule

// File: hdl/imu_frame_deframer_checksum_core.sv
// Frame deframer: one received byte per cycle, one result per good frame.
// A good frame is queued with its checksum byte and then output-registered.
// Throughput: one byte per cycle; input stalls only while the two-entry
// frame queue is full because the output is stalled.
// Reset (async, active low) clears position, sum, queue and output valid;
// bus_address returns to 0xFF and message_id to 0x32.
module imu_frame_deframer_checksum_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ifd_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ifd_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ifd_pkg::WORD_W-1:0]    roll_bits_o,
  output logic [ifd_pkg::WORD_W-1:0]    pitch_bits_o,
  output logic [ifd_pkg::WORD_W-1:0]    yaw_bits_o,
  output logic [ifd_pkg::WORD_W-1:0]    latitude_bits_o,
  output logic [ifd_pkg::WORD_W-1:0]    longitude_bits_o,
  output logic [ifd_pkg::WORD_W-1:0]    altitude_bits_o,
  output logic                          in_range_o
);
  import ifd_pkg::*;

  logic   acc, push, pop, full, empty;
  frame_t push_frame, head_frame, out_frame;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign acc         = in_valid_i && !full;

  ifd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .frame_o     (push_frame)
  );

  ifd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_frame),
    .pop_i   (pop),
    .rdata_o (head_frame),
    .full_o  (full),
    .empty_o (empty)
  );

  ifd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .frame_i     (head_frame),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .frame_o     (out_frame),
    .in_range_o  (in_range_o)
  );

  assign roll_bits_o      = out_frame.roll;
  assign pitch_bits_o     = out_frame.pitch;
  assign yaw_bits_o       = out_frame.yaw;
  assign latitude_bits_o  = out_frame.lat;
  assign longitude_bits_o = out_frame.lon;
  assign altitude_bits_o  = out_frame.alt;

endmodule

// File: hdl/ifd_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on ifd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ifd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ifd_pkg::WORD_W-1:0]    roll_bits_o,
  input logic [ifd_pkg::WORD_W-1:0]    altitude_bits_o,
  input logic                          in_range_o
);
  import ifd_pkg::*;

  `IFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output dropped while stalled")
  `IFD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(roll_bits_o) && $stable(altitude_bits_o), "stalled result changed")
  `IFD_ASSERT(a_roll_range, !(out_valid_o && in_range_o) || (roll_bits_o[WORD_W-2:0] <= F_180), "roll flagged in range but out of bounds")
  `IFD_ASSERT(a_alt_nonzero, !(out_valid_o && in_range_o) || (altitude_bits_o[WORD_W-2:0] >= F_ONE), "altitude near zero flagged in range")

endmodule

bind imu_frame_deframer_checksum_core ifd_checker u_ifd_checker (.*);

// File: dv/imu_frame_deframer_checksum_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for imu_frame_deframer_checksum_core: byte stream in,
// decoded frames out, compared against an in-bench frame predictor.
// Depends on ifd_pkg and the core RTL.
module imu_frame_deframer_checksum_core_test;
  import ifd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;
  localparam int unsigned PAY_BYTES   = 26;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_BYTES = 250;

  typedef struct packed {
    frame_t words;
    logic   in_range;
  } deframed_t;

  class deframe_scoreboard;
    logic [BYTE_W-1:0] bus_addr;
    logic [BYTE_W-1:0] msg_id;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] store [PAY_BYTES];
    deframed_t frames_due [$];
    int errors;
    int frames_checked;
    int good_frames;
    int dropped_frames;

    function new();
      bus_addr = BUS_ADDR_RST;
      msg_id   = MSG_ID_RST;
      pos      = POS_HUNT;
      sum      = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (idx == CFG_BUS_ADDRESS) begin
        bus_addr = data;
      end else if (idx == CFG_MESSAGE_ID) begin
        msg_id = data;
      end
    endfunction

    function void restart(logic [BYTE_W-1:0] b);
      sum = '0;
      pos = (b == PREAMBLE_BYTE) ? POS_ADDR : POS_HUNT;
    endfunction

    function logic [WORD_W-1:0] word_at(int base);
      return {store[base], store[base+1], store[base+2], store[base+3]};
    endfunction

    // NaN and infinity exceed every finite magnitude bound.
    function bit outside_bounds(logic [WORD_W-1:0] v, logic [WORD_W-2:0] lo,
                                logic [WORD_W-2:0] hi);
      return v[WORD_W-1] ? (v[WORD_W-2:0] > lo) : (v[WORD_W-2:0] > hi);
    endfunction

    function bit below_one(logic [WORD_W-1:0] v);
      return v[WORD_W-2:0] < F_ONE;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] want;
      logic [BYTE_W-1:0] total;
      deframed_t f;
      if (pos == POS_ADDR || pos == POS_ID || pos == POS_LEN) begin
        want = (pos == POS_ADDR) ? bus_addr : (pos == POS_ID) ? msg_id : LENGTH_BYTE;
        if (b == want) begin
          sum = sum + b;
          pos = pos + 1'b1;
        end else begin
          restart(b);
        end
      end else if (pos >= POS_PAYLOAD && pos <= POS_LAST_PAY) begin
        store[pos - POS_PAYLOAD] = b;
        sum = sum + b;
        pos = pos + 1'b1;
      end else if (pos == POS_CHECKSUM) begin
        total = sum + b;
        pos   = POS_HUNT;
        sum   = '0;
        if (total != '0) begin
          dropped_frames++;
        end else begin
          f.words.roll = word_at(0);
          f.words.pitch = word_at(4);
          f.words.yaw = word_at(8);
          f.words.lat = word_at(12);
          f.words.lon = word_at(16);
          f.words.alt = word_at(20);
          f.in_range = !(outside_bounds(f.words.roll, F_180, F_180) ||
                         outside_bounds(f.words.pitch, F_180, F_180) ||
                         outside_bounds(f.words.yaw, F_180, F_180) ||
                         below_one(f.words.yaw) ||
                         outside_bounds(f.words.lat, F_90, F_90) ||
                         below_one(f.words.lat) ||
                         outside_bounds(f.words.lon, F_180, F_180) ||
                         below_one(f.words.lon) ||
                         outside_bounds(f.words.alt, F_200, F_1000) ||
                         below_one(f.words.alt));
          frames_due.push_back(f);
          good_frames++;
        end
      end else begin
        restart(b);
      end
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void match_frame(deframed_t got);
      deframed_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual %h", $time, got);
        return;
      end
      want = frames_due.pop_front();
      frames_checked++;
      compare_field("roll", want.words.roll, got.words.roll);
      compare_field("pitch", want.words.pitch, got.words.pitch);
      compare_field("yaw", want.words.yaw, got.words.yaw);
      compare_field("latitude", want.words.lat, got.words.lat);
      compare_field("longitude", want.words.lon, got.words.lon);
      compare_field("altitude", want.words.alt, got.words.alt);
      compare_field("in_range", 32'(want.in_range), 32'(got.in_range));
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [BYTE_W-1:0]    cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [WORD_W-1:0]    roll_bits_o;
  logic [WORD_W-1:0]    pitch_bits_o;
  logic [WORD_W-1:0]    yaw_bits_o;
  logic [WORD_W-1:0]    latitude_bits_o;
  logic [WORD_W-1:0]    longitude_bits_o;
  logic [WORD_W-1:0]    altitude_bits_o;
  logic                 in_range_o;

  deframe_scoreboard sb;
  deframed_t         seen_frame;
  logic [BYTE_W-1:0] tx_q [$];
  logic [WORD_W-1:0] vals [6];
  logic [BYTE_W-1:0] tail [2];
  int                gap_pct    = 0;
  int                stall_pct  = 0;
  int                bytes_sent = 0;
  int                hold_left  = 0;
  bit                hold_req   = 1'b0;

  imu_frame_deframer_checksum_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .roll_bits_o     (roll_bits_o),
    .pitch_bits_o    (pitch_bits_o),
    .yaw_bits_o      (yaw_bits_o),
    .latitude_bits_o (latitude_bits_o),
    .longitude_bits_o(longitude_bits_o),
    .altitude_bits_o (altitude_bits_o),
    .in_range_o      (in_range_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.take_byte(rx_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_frame.words.roll = roll_bits_o;
        seen_frame.words.pitch = pitch_bits_o;
        seen_frame.words.yaw = yaw_bits_o;
        seen_frame.words.lat = latitude_bits_o;
        seen_frame.words.lon = longitude_bits_o;
        seen_frame.words.alt = altitude_bits_o;
        seen_frame.in_range = in_range_o;
        sb.match_frame(seen_frame);
      end
    end
  end

  // Output back-pressure: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("imu_frame_deframer_checksum_core_test NOT OK");
    $finish;
  end

  function automatic logic [WORD_W-1:0] edge_value(int k);
    case (k)
      0:       return 32'h43340000;
      1:       return 32'h43340001;
      2:       return 32'hC3340000;
      3:       return 32'hC3340001;
      4:       return 32'h3F800000;
      5:       return 32'h3F7FFFFF;
      6:       return 32'hBF800000;
      7:       return 32'hBF7FFFFF;
      8:       return 32'h00000000;
      9:       return 32'h80000000;
      10:      return 32'h7F800000;
      11:      return 32'hFF800000;
      12:      return 32'h7FC00000;
      13:      return 32'hFFFFFFFF;
      14:      return 32'h42B40000;
      15:      return 32'h42B40001;
      16:      return 32'hC2B40000;
      17:      return 32'hC2B40001;
      18:      return 32'hC3480000;
      19:      return 32'hC3480001;
      20:      return 32'h447A0000;
      21:      return 32'h447A0001;
      default: return 32'hC47A0000;
    endcase
  endfunction

  // Magnitude in [1, 64): passes every bound.
  function automatic logic [WORD_W-1:0] plausible();
    return {1'($urandom_range(1)), 8'($urandom_range(132, 127)), 23'($urandom)};
  endfunction

  function automatic logic [WORD_W-1:0] any_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return plausible();
    if (r < 85) return edge_value($urandom_range(22));
    return $urandom;
  endfunction

  function automatic void fill_values();
    bit all_ok;
    all_ok = $urandom_range(1);
    foreach (vals[i]) vals[i] = all_ok ? plausible() : any_value();
    tail[0] = 8'($urandom);
    tail[1] = 8'($urandom);
  endfunction

  function automatic void push_frame(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] id,
                                     logic [BYTE_W-1:0] len, logic [BYTE_W-1:0] flip);
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] pb;
    s = a + id + len;
    tx_q.push_back(PREAMBLE_BYTE);
    tx_q.push_back(a);
    tx_q.push_back(id);
    tx_q.push_back(len);
    for (int i = 0; i < PAY_BYTES; i++) begin
      pb = (i < CAPT_BYTES) ? vals[i/4][8*(3 - i%4) +: 8] : tail[i - CAPT_BYTES];
      tx_q.push_back(pb);
      s = s + pb;
    end
    tx_q.push_back((8'd0 - s) ^ flip);
  endfunction

  function automatic logic [BYTE_W-1:0] off_by(logic [BYTE_W-1:0] v);
    if ($urandom_range(3) == 0 && v != PREAMBLE_BYTE) return PREAMBLE_BYTE;
    return v ^ 8'($urandom_range(255, 1));
  endfunction

  // Mostly good frames with random content; the rest corrupted or noise.
  function automatic void queue_random_frame();
    int kind;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] flip;
    fill_values();
    a    = sb.bus_addr;
    id   = sb.msg_id;
    len  = LENGTH_BYTE;
    flip = '0;
    kind = $urandom_range(99);
    if (kind < 6) begin
      flip = 8'($urandom_range(255, 1));
    end else if (kind < 11) begin
      a = off_by(a);
    end else if (kind < 15) begin
      id = off_by(id);
    end else if (kind < 19) begin
      len = off_by(len);
    end else if (kind < 25) begin
      repeat ($urandom_range(8, 1)) begin
        tx_q.push_back(($urandom_range(3) == 0) ? PREAMBLE_BYTE : 8'($urandom));
      end
    end
    push_frame(a, id, len, flip);
    if (kind >= 25 && kind < 30) begin
      repeat ($urandom_range(30, 1)) void'(tx_q.pop_back());
    end
  endfunction

  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.frames_due.size() != 0 || hold_req || hold_left != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] id;
    int goal;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // In range at the exact bounds.
    vals = '{32'h42C80000, 32'hC2C80000, 32'h3F800000, 32'h42B40000, 32'hC3340000,
             32'h447A0000};
    tail = '{8'h00, 8'hFF};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    vals = '{default: 32'h00000000};
    tail = '{8'h00, 8'h00};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    vals = '{default: 32'hFFFFFFFF};
    tail = '{8'hFF, 8'hFF};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    // Preamble in the address slot restarts; preamble bytes inside payload are data.
    tx_q.push_back(PREAMBLE_BYTE);
    vals = '{32'hFAFAFAFA, 32'h43340000, 32'hC3340000, 32'h3F7FFFFF, 32'h7F800000,
             32'hC3480000};
    tail = '{PREAMBLE_BYTE, PREAMBLE_BYTE};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    // Wrong message id.
    tx_q.push_back(PREAMBLE_BYTE);
    tx_q.push_back(sb.bus_addr);
    tx_q.push_back(8'h00);
    vals = '{32'hC3340001, 32'h43340001, 32'hBF800000, 32'hC2B40000, 32'h43340000,
             32'hC3480000};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    // Bad checksum equal to the preamble, followed by a stray header.
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    tx_q[tx_q.size()-1] = (tx_q[tx_q.size()-1] == PREAMBLE_BYTE) ? 8'h00 : PREAMBLE_BYTE;
    tx_q.push_back(sb.bus_addr);
    tx_q.push_back(sb.msg_id);
    tx_q.push_back(LENGTH_BYTE);
    vals = '{32'h80000000, 32'h00000000, 32'hBF7FFFFF, 32'h42B40001, 32'hC3340001,
             32'h447A0001};
    push_frame(sb.bus_addr, sb.msg_id, LENGTH_BYTE, '0);
    send_queued();

    // Writes to unmapped indexes must leave the registers alone.
    settle();
    write_reg(CFG_IDX_SPARE, 8'h00);
    write_reg(CFG_IDX_TOP, 8'h5A);
    vals = '{32'h42C80000, 32'hC2C80000, 32'h3F800000, 32'h42B40000, 32'hC3340000,
             32'h447A0000};
    push_frame(BUS_ADDR_RST, MSG_ID_RST, LENGTH_BYTE, '0);
    send_queued();

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          a  = 8'h00;
          id = 8'h00;
        end
        1: begin
          a  = PREAMBLE_BYTE;
          id = PREAMBLE_BYTE;
        end
        2: begin
          a  = 8'hFF;
          id = 8'hFF;
        end
        5: begin
          a  = BUS_ADDR_RST;
          id = MSG_ID_RST;
        end
        default: begin
          a  = 8'($urandom);
          id = 8'($urandom);
        end
      endcase
      write_reg(CFG_BUS_ADDRESS, a);
      write_reg(CFG_MESSAGE_ID, id);
      if (ph == 3) write_reg(CFG_IDX_TOP, 8'($urandom));
      gap_pct   = (ph % 4 == 1) ? 56 : (ph % 4 == 3) ? 10 : 0;
      stall_pct = (ph % 4 == 2) ? 56 : (ph % 4 == 3) ? 10 : 0;
      if (ph == 0) hold_req = 1'b1;
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        queue_random_frame();
        send_queued();
      end
    end
    settle();

    $display("Sent %0d bytes across six address/id settings and four handshake mixes,",
             bytes_sent);
    $display("%0d frames decoded and compared, %0d dropped on bad checksum.",
             sb.frames_checked, sb.dropped_frames);
    if (sb.errors == 0 && sb.frames_due.size() == 0) begin
      $display("imu_frame_deframer_checksum_core_test OK");
    end else begin
      $display("imu_frame_deframer_checksum_core_test NOT OK");
    end
    $finish;
  end

endmodule
